[sv/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV pixel pipeline.
package rhsv_pkg;

	localparam int unsigned CH_W  = 8;   // width of one colour channel
	localparam int unsigned QW    = 16;  // width of hue and saturation quotients
	localparam int unsigned HUE_W = 11;  // holds 6 * chroma and the hue numerator

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

	// Everything the front end hands to the two dividers for one pixel.
	typedef struct packed {
		logic [CH_W-1:0]  vmax;
		logic             sat_zero;
		logic             hue_zero;
		logic [CH_W-1:0]  sat_hi;
		logic [QW-1:0]    sat_lo;
		logic [HUE_W-1:0] hue_num;
		logic [HUE_W-1:0] hue_den;
	} front_t;

endpackage

[sv/rhsv_front.sv]
// Front end: max/min selection, chroma, and the dividend and divisor set-up for both dividers.
module rhsv_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [rhsv_pkg::CH_W-1:0]   red,
	input  logic [rhsv_pkg::CH_W-1:0]   green,
	input  logic [rhsv_pkg::CH_W-1:0]   blue,
	output logic                        out_vld,
	output rhsv_pkg::front_t            out_data
);

	logic [rhsv_pkg::CH_W-1:0] vmax_c, vmin_c;
	rhsv_pkg::max_sel_t        sel_c;
	logic signed [rhsv_pkg::CH_W:0] diff_c;

	logic                      vld_s1;
	logic [rhsv_pkg::CH_W-1:0] vmax_s1, vmin_s1;
	rhsv_pkg::max_sel_t        sel_s1;
	logic signed [rhsv_pkg::CH_W:0] diff_s1;

	logic [rhsv_pkg::CH_W-1:0]  chroma;
	logic [rhsv_pkg::HUE_W-1:0] c6;
	logic signed [rhsv_pkg::HUE_W:0] base, wsum, wrapped;
	logic [rhsv_pkg::CH_W+rhsv_pkg::QW-1:0] sat_num;
	rhsv_pkg::front_t          nxt;

	logic                      vld_s2;
	rhsv_pkg::front_t          data_s2;

	// Stage 1: largest and smallest channel; on ties blue beats green beats red.
	always_comb begin
		vmax_c = red;
		if (green > vmax_c) vmax_c = green;
		if (blue > vmax_c) vmax_c = blue;
		vmin_c = red;
		if (green < vmin_c) vmin_c = green;
		if (blue < vmin_c) vmin_c = blue;
		priority if (blue == vmax_c) begin
			sel_c  = rhsv_pkg::SEL_BLUE;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end else if (green == vmax_c) begin
			sel_c  = rhsv_pkg::SEL_GREEN;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sel_c  = rhsv_pkg::SEL_RED;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vmax_s1 <= vmax_c;
			vmin_s1 <= vmin_c;
			sel_s1  <= sel_c;
			diff_s1 <= diff_c;
		end
	end

	// Stage 2: hue numerator wrapped into [0, 6*chroma) and saturation dividend chroma*65535.
	always_comb begin
		chroma = vmax_s1 - vmin_s1;
		c6     = rhsv_pkg::HUE_W'({chroma, 2'b00}) + rhsv_pkg::HUE_W'({chroma, 1'b0});
		unique case (sel_s1)
			rhsv_pkg::SEL_BLUE:  base = (rhsv_pkg::HUE_W+1)'({chroma, 2'b00});
			rhsv_pkg::SEL_GREEN: base = (rhsv_pkg::HUE_W+1)'({chroma, 1'b0});
			default:             base = '0;
		endcase
		wsum    = base + (rhsv_pkg::HUE_W+1)'(diff_s1);
		wrapped = wsum[rhsv_pkg::HUE_W] ? wsum + $signed({1'b0, c6}) : wsum;
		sat_num = {chroma, rhsv_pkg::QW'(0)} - (rhsv_pkg::CH_W+rhsv_pkg::QW)'(chroma);

		nxt.vmax     = vmax_s1;
		nxt.sat_zero = (vmax_s1 == '0);
		nxt.hue_zero = (chroma == '0);
		nxt.sat_hi   = sat_num[rhsv_pkg::CH_W+rhsv_pkg::QW-1:rhsv_pkg::QW];
		nxt.sat_lo   = sat_num[rhsv_pkg::QW-1:0];
		nxt.hue_num  = wrapped[rhsv_pkg::HUE_W-1:0];
		nxt.hue_den  = c6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

	assign out_vld  = vld_s2;
	assign out_data = data_s2;

endmodule

[sv/rhsv_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module rhsv_div #(
	parameter int unsigned DW = 8,
	parameter int unsigned TW = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [DW-1:0]             in_rem,
	input  logic [rhsv_pkg::QW-1:0]   in_lo,
	input  logic [DW-1:0]             in_den,
	input  logic [TW-1:0]             in_tag,
	output logic                      out_vld,
	output logic [rhsv_pkg::QW-1:0]   out_quo,
	output logic [TW-1:0]             out_tag
);

	localparam int unsigned NS = rhsv_pkg::QW;

	// The dividend's low bits shift out of lo_s at the top while quotient bits shift in below.
	logic                    vld_s [NS];
	logic [rhsv_pkg::QW-1:0] lo_s  [NS];
	logic [TW-1:0]           tag_s [NS];
	logic [DW-1:0]           rem_s [NS-1];
	logic [DW-1:0]           den_s [NS-1];

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic                    vld_in;
		logic [DW-1:0]           rem_in, den_in;
		logic [rhsv_pkg::QW-1:0] lo_in;
		logic [TW-1:0]           tag_in;
		logic [DW:0]             trial;
		logic                    ge;

		if (i == 0) begin : g_first
			assign vld_in = in_vld;
			assign rem_in = in_rem;
			assign den_in = in_den;
			assign lo_in  = in_lo;
			assign tag_in = in_tag;
		end else begin : g_next
			assign vld_in = vld_s[i-1];
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign lo_in  = lo_s[i-1];
			assign tag_in = tag_s[i-1];
		end

		assign trial = {rem_in, lo_in[rhsv_pkg::QW-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[i]  <= {lo_in[rhsv_pkg::QW-2:0], ge};
				tag_s[i] <= tag_in;
			end
		end

		if (i < NS - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign out_quo = lo_s[NS-1];
	assign out_tag = tag_s[NS-1];

endmodule

[sv/rgb_to_hsv_pixel_core.sv]
// Top level of the RGB to HSV pixel converter.
// A request passes through the front-end stages, the divider stages and the output register before reaching m_tdata.
// Throughput: one pixel per cycle unless the output stalls; the sixteen-stage dividers take one quotient bit per stage.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (arst_n low) clears every valid bit at once; the data registers are not reset.
module rgb_to_hsv_pixel_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // hue [15:0], saturation [31:16], brightness [39:32]
);

	localparam int unsigned TAG_W = rhsv_pkg::CH_W + 1;

	logic                      adv;
	logic                      fr_vld;
	rhsv_pkg::front_t          fr_data;
	logic                      sat_vld, hue_vld;
	logic [rhsv_pkg::QW-1:0]   sat_quo, hue_quo;
	logic [TAG_W-1:0]          sat_tag;
	logic [0:0]                hue_tag;

	logic                      vld_q;
	logic [rhsv_pkg::QW-1:0]   hue_q, sat_q;
	logic [rhsv_pkg::CH_W-1:0] bright_q;

	assign adv      = !vld_q || m_tready;
	assign s_tready = adv;

	rhsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (s_tvalid),
		.red      (s_tdata[7:0]),
		.green    (s_tdata[15:8]),
		.blue     (s_tdata[23:16]),
		.out_vld  (fr_vld),
		.out_data (fr_data)
	);

	rhsv_div #(
		.DW (rhsv_pkg::CH_W),
		.TW (TAG_W)
	) u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (fr_vld),
		.in_rem  (fr_data.sat_hi),
		.in_lo   (fr_data.sat_lo),
		.in_den  (fr_data.vmax),
		.in_tag  ({fr_data.vmax, fr_data.sat_zero}),
		.out_vld (sat_vld),
		.out_quo (sat_quo),
		.out_tag (sat_tag)
	);

	rhsv_div #(
		.DW (rhsv_pkg::HUE_W),
		.TW (1)
	) u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (fr_vld),
		.in_rem  (fr_data.hue_num),
		.in_lo   ('0),
		.in_den  (fr_data.hue_den),
		.in_tag  (fr_data.hue_zero),
		.out_vld (hue_vld),
		.out_quo (hue_quo),
		.out_tag (hue_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= sat_vld;
		end
	end

	// A zero divisor leaves the quotient at all ones, so gray and black pixels are forced here.
	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q    <= hue_tag[0] ? '0 : hue_quo;
			sat_q    <= sat_tag[0] ? '0 : sat_quo;
			bright_q <= sat_tag[TAG_W-1:1];
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {bright_q, sat_q, hue_q};

`ifndef SYNTHESIS
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		sat_vld == hue_vld)
		else $error("saturation and hue dividers out of step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(fr_data) && $stable(fr_vld))
		else $error("front end moved during a stall");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && bright_q == '0 |-> sat_q == '0)
		else $error("black pixel with non-zero saturation");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && bright_q != '0 && sat_q == '0 |-> hue_q == '0)
		else $error("gray pixel with non-zero hue");
`endif

endmodule
